// ===== rtl/voxel_exposed_face_check_unit_assert.svh =====
// Assertion macros used by the top-level RTL file of the voxel exposed face check unit.
`ifndef VOXEL_EXPOSED_FACE_CHECK_UNIT_ASSERT_SVH
`define VOXEL_EXPOSED_FACE_CHECK_UNIT_ASSERT_SVH

// Checks the property at every rising clock edge outside of reset.
`define VEFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks the property at every rising clock edge, during reset as well.
`define VEFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/vefc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vefc_pkg;

  localparam int TYPE_W = 8;

  typedef logic [TYPE_W-1:0] cell_type_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef logic [2:0] step_t;

  localparam step_t STEP_CENTER = 3'd0;
  localparam step_t STEP_X_DN   = 3'd1;
  localparam step_t STEP_X_UP   = 3'd2;
  localparam step_t STEP_Y_DN   = 3'd3;
  localparam step_t STEP_Y_UP   = 3'd4;
  localparam step_t STEP_Z_DN   = 3'd5;
  localparam step_t STEP_Z_UP   = 3'd6;

  typedef struct packed {
    logic       valid;
    logic       visible;
    cell_type_t cell_type;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/vefc_grid_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vefc_grid_mem #(
  parameter int AW = 14
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire vefc_pkg::cell_type_t wr_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output vefc_pkg::cell_type_t      rd_data_o
);
  import vefc_pkg::*;

  cell_type_t mem_q [2**AW];
  cell_type_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/vefc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vefc_ctrl #(
  parameter int GRID_SIDE  = 16,
  parameter int GRID_DEPTH = 64,
  parameter int XW         = 4,
  parameter int ZW         = 6,
  parameter int AW         = 14
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 in_kind_i,
  input  wire logic [3:0]           in_x_pos_i,
  input  wire logic [3:0]           in_y_pos_i,
  input  wire logic [5:0]           in_z_pos_i,
  input  wire vefc_pkg::cell_type_t in_block_type_i,
  input  wire vefc_pkg::cell_type_t air_code_i,
  output logic                      mem_wr_en_o,
  output logic [AW-1:0]             mem_wr_addr_o,
  output vefc_pkg::cell_type_t      mem_wr_data_o,
  output logic                      mem_rd_en_o,
  output logic [AW-1:0]             mem_rd_addr_o,
  input  wire vefc_pkg::cell_type_t mem_rd_data_i,
  output vefc_pkg::result_t         res_o,
  input  wire logic                 res_ready_i
);
  import vefc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e     st_q, st_d;
  step_t      step_q, step_d;
  step_t      pend_step_q;
  logic       pend_q;
  logic [XW-1:0] x_q;
  logic [XW-1:0] y_q;
  logic [ZW-1:0] z_q;
  logic       inside_q;
  logic       edge_q;
  logic       any_air_q;
  cell_type_t type_q;

  logic          accept;
  logic          in_inside;
  logic          in_edge;
  logic [XW-1:0] in_x;
  logic [XW-1:0] in_y;
  logic [ZW-1:0] in_z;

  assign in_x = XW'(in_x_pos_i);
  assign in_y = XW'(in_y_pos_i);
  assign in_z = ZW'(in_z_pos_i);

  assign in_inside = (32'(in_x_pos_i) < GRID_SIDE) && (32'(in_y_pos_i) < GRID_SIDE) &&
                     (32'(in_z_pos_i) < GRID_DEPTH);
  assign in_edge = (in_x_pos_i == 4'd0) || (32'(in_x_pos_i) == GRID_SIDE - 1) ||
                   (in_y_pos_i == 4'd0) || (32'(in_y_pos_i) == GRID_SIDE - 1) ||
                   (in_z_pos_i == 6'd0) || (32'(in_z_pos_i) == GRID_DEPTH - 1);

  assign in_stall_o = (st_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign mem_wr_en_o   = accept && (in_kind_i == KIND_WRITE) && in_inside;
  assign mem_wr_addr_o = {in_x, in_y, in_z};
  assign mem_wr_data_o = in_block_type_i;

  always_comb begin
    unique case (step_q)
      STEP_CENTER: mem_rd_addr_o = {x_q, y_q, z_q};
      STEP_X_DN:   mem_rd_addr_o = {x_q - XW'(1), y_q, z_q};
      STEP_X_UP:   mem_rd_addr_o = {x_q + XW'(1), y_q, z_q};
      STEP_Y_DN:   mem_rd_addr_o = {x_q, y_q - XW'(1), z_q};
      STEP_Y_UP:   mem_rd_addr_o = {x_q, y_q + XW'(1), z_q};
      STEP_Z_DN:   mem_rd_addr_o = {x_q, y_q, z_q - ZW'(1)};
      STEP_Z_UP:   mem_rd_addr_o = {x_q, y_q, z_q + ZW'(1)};
      default:     mem_rd_addr_o = {x_q, y_q, z_q};
    endcase
  end

  assign mem_rd_en_o = (st_q == ST_READ);

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    unique case (st_q)
      ST_IDLE: begin
        step_d = STEP_CENTER;
        if (accept && (in_kind_i == KIND_QUERY)) begin
          st_d = in_inside ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        step_d = step_q + 3'd1;
        if (step_q == STEP_Z_UP) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        st_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      step_q <= STEP_CENTER;
      pend_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      pend_q <= (st_q == ST_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    pend_step_q <= step_q;
    if (accept && (in_kind_i == KIND_QUERY)) begin
      x_q       <= in_x;
      y_q       <= in_y;
      z_q       <= in_z;
      inside_q  <= in_inside;
      edge_q    <= in_edge;
      any_air_q <= 1'b0;
      type_q    <= '0;
    end else if (pend_q) begin
      if (pend_step_q == STEP_CENTER) begin
        type_q <= mem_rd_data_i;
      end else if (mem_rd_data_i == air_code_i) begin
        any_air_q <= 1'b1;
      end
    end
  end

  assign res_o.valid     = (st_q == ST_DONE);
  assign res_o.visible   = inside_q && (type_q != air_code_i) && (edge_q || any_air_q);
  assign res_o.cell_type = type_q;

endmodule

`default_nettype wire

// ===== rtl/voxel_exposed_face_check_unit.sv =====
// A write request is stored at its accepting clock edge.
// A query request inside the grid reads the center cell and its six neighbors
// from the single read port of the grid memory, one read per cycle, before its
// result is offered; a query outside the grid offers its result without reads.
// The next request is taken once the result has moved to the output register.
// Reset clears control state and the air code; grid contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

`include "voxel_exposed_face_check_unit_assert.svh"

module voxel_exposed_face_check_unit #(
  parameter int GRID_SIDE  = 16,
  parameter int GRID_DEPTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire vefc_pkg::cell_type_t cfg_air_code_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 in_kind_i,
  input  wire logic [3:0]           in_x_pos_i,
  input  wire logic [3:0]           in_y_pos_i,
  input  wire logic [5:0]           in_z_pos_i,
  input  wire vefc_pkg::cell_type_t in_block_type_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      out_visible_o,
  output vefc_pkg::cell_type_t      out_cell_type_o
);
  import vefc_pkg::*;

  localparam int XW = $clog2(GRID_SIDE);
  localparam int ZW = $clog2(GRID_DEPTH);
  localparam int AW = 2 * XW + ZW;

  cell_type_t    air_code_q;
  logic          out_valid_q;
  logic          out_visible_q;
  cell_type_t    out_cell_type_q;
  result_t       res;
  logic          res_ready;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  cell_type_t    mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  cell_type_t    mem_rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      air_code_q <= '0;
    end else if (cfg_we_i) begin
      air_code_q <= cfg_air_code_i;
    end
  end

  vefc_ctrl #(
    .GRID_SIDE  (GRID_SIDE),
    .GRID_DEPTH (GRID_DEPTH),
    .XW         (XW),
    .ZW         (ZW),
    .AW         (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_kind_i       (in_kind_i),
    .in_x_pos_i      (in_x_pos_i),
    .in_y_pos_i      (in_y_pos_i),
    .in_z_pos_i      (in_z_pos_i),
    .in_block_type_i (in_block_type_i),
    .air_code_i      (air_code_q),
    .mem_wr_en_o     (mem_wr_en),
    .mem_wr_addr_o   (mem_wr_addr),
    .mem_wr_data_o   (mem_wr_data),
    .mem_rd_en_o     (mem_rd_en),
    .mem_rd_addr_o   (mem_rd_addr),
    .mem_rd_data_i   (mem_rd_data),
    .res_o           (res),
    .res_ready_i     (res_ready)
  );

  vefc_grid_mem #(
    .AW (AW)
  ) u_grid_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_visible_q   <= res.visible;
      out_cell_type_q <= res.cell_type;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_visible_o   = out_visible_q;
  assign out_cell_type_o = out_cell_type_q;

  `VEFC_ASSERT(a_query_occupies_unit,
               (in_valid_i && !in_stall_o && in_kind_i == KIND_QUERY) |=> in_stall_o,
               "A query request did not occupy the unit.")
  `VEFC_ASSERT(a_write_only_on_accept,
               mem_wr_en |-> (in_valid_i && !in_stall_o && in_kind_i == KIND_WRITE),
               "The grid was written without an accepted write request.")
  `VEFC_ASSERT_ALWAYS(a_result_while_busy,
                      res.valid |-> (in_stall_o && !mem_wr_en),
                      "A result was offered while the unit was idle or writing.")

endmodule

`default_nettype wire
